>>> sv/jtl_pkg.sv
// Package of the JSON token lexer: token kinds, lexer modes, record types and character codes.
package jtl_pkg;

  localparam int unsigned MAX_TEXT_BYTES_DEF = 65536;

  localparam int unsigned START_W = 16;
  localparam int unsigned LEN_W = 17;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;

  typedef enum logic [3:0] {
    KIND_OBRACE   = 4'd0,
    KIND_CBRACE   = 4'd1,
    KIND_OBRACKET = 4'd2,
    KIND_CBRACKET = 4'd3,
    KIND_COMMA    = 4'd4,
    KIND_COLON    = 4'd5,
    KIND_STRING   = 4'd6,
    KIND_NUMBER   = 4'd7,
    KIND_BOOLEAN  = 4'd8,
    KIND_ERROR    = 4'd9
  } tok_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_KEYWORD = 2'd3
  } lex_mode_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [START_W-1:0] start;
    tok_kind_t          kind;
  } tok_t;

  // All tokens caused by one input byte.
  typedef struct packed {
    logic v0;
    logic two;
    tok_t t0;
    tok_t t1;
  } byte_rec_t;

  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_R        = 8'h72;
  localparam logic [7:0] CH_U        = 8'h75;
  localparam logic [7:0] CH_E        = 8'h65;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_A        = 8'h61;
  localparam logic [7:0] CH_L        = 8'h6C;
  localparam logic [7:0] CH_S        = 8'h73;

endpackage

>>> sv/jtl_front.sv
// Front end of the JSON token lexer: accepts bytes and classifies them into token records.
module jtl_front import jtl_pkg::*; #(
  parameter int unsigned MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       push,
  output byte_rec_t  rec
);

  localparam int unsigned PW = $clog2(MAX_TEXT_BYTES + 1);
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_TEXT_BYTES);

  lex_mode_t          mode, mode_next;
  logic [PW-1:0]      byte_position, byte_position_next;
  logic [START_W-1:0] pending_start, pending_start_next;
  logic [LEN_W-1:0]   pending_length, pending_length_next;
  logic [2:0]         keyword_index, keyword_index_next;
  logic               keyword_is_false, keyword_is_false_next;

  function automatic logic [7:0] kw_char(input logic is_false, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case ({is_false, idx})
      4'b0000: ch = CH_T;
      4'b0001: ch = CH_R;
      4'b0010: ch = CH_U;
      4'b0011: ch = CH_E;
      4'b1000: ch = CH_F;
      4'b1001: ch = CH_A;
      4'b1010: ch = CH_L;
      4'b1011: ch = CH_S;
      4'b1100: ch = CH_E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic byte_rec_t add_tok(input byte_rec_t r, input tok_kind_t kind,
                                        input logic [START_W-1:0] start,
                                        input logic [LEN_W-1:0] len);
    byte_rec_t o;
    o = r;
    if (!r.v0) begin
      o.v0 = 1'b1;
      o.t0 = '{len: len, start: start, kind: kind};
    end else if (!r.two) begin
      o.two = 1'b1;
      o.t1 = '{len: len, start: start, kind: kind};
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_IDLE;
      byte_position    <= '0;
      pending_start    <= '0;
      pending_length   <= '0;
      keyword_index    <= '0;
      keyword_is_false <= 1'b0;
    end else begin
      mode             <= mode_next;
      byte_position    <= byte_position_next;
      pending_start    <= pending_start_next;
      pending_length   <= pending_length_next;
      keyword_index    <= keyword_index_next;
      keyword_is_false <= keyword_is_false_next;
    end
  end

  always_comb begin
    logic               in_range;
    logic               do_idle;
    logic               is_digit;
    logic               kw_match;
    logic [2:0]         target;
    logic [START_W-1:0] pos16;
    byte_rec_t          r;

    mode_next             = mode;
    byte_position_next    = byte_position;
    pending_start_next    = pending_start;
    pending_length_next   = pending_length;
    keyword_index_next    = keyword_index;
    keyword_is_false_next = keyword_is_false;
    r                     = '0;
    do_idle               = 1'b0;
    in_range              = byte_position < MAX_POS;
    is_digit              = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    pos16                 = START_W'(byte_position);
    target                = keyword_is_false ? 3'd5 : 3'd4;
    kw_match              = (keyword_index < target) &&
                            (text_byte == kw_char(keyword_is_false, keyword_index));

    if (accept) begin
      if (in_range) begin
        byte_position_next = byte_position + 1'b1;
        unique case (mode)
          MODE_STRING: begin
            pending_length_next = pending_length + 1'b1;
            if (text_byte == CH_QUOTE) begin
              r = add_tok(r, KIND_STRING, pending_start, pending_length_next);
              mode_next = MODE_IDLE;
            end
          end
          MODE_NUMBER: begin
            if (is_digit) begin
              pending_length_next = pending_length + 1'b1;
            end else begin
              r = add_tok(r, KIND_NUMBER, pending_start, pending_length);
              mode_next = MODE_IDLE;
              do_idle = 1'b1;
            end
          end
          MODE_KEYWORD: begin
            if (kw_match) begin
              keyword_index_next  = keyword_index + 3'd1;
              pending_length_next = pending_length + 1'b1;
              if (keyword_index_next == target) begin
                r = add_tok(r, KIND_BOOLEAN, pending_start, pending_length_next);
                mode_next = MODE_IDLE;
              end
            end else begin
              r = add_tok(r, KIND_ERROR, pending_start, pending_length);
              mode_next = MODE_IDLE;
              do_idle = 1'b1;
            end
          end
          default: begin
            do_idle = 1'b1;
          end
        endcase

        if (mode_next == MODE_IDLE) begin
          pending_start_next    = '0;
          pending_length_next   = '0;
          keyword_index_next    = '0;
          keyword_is_false_next = 1'b0;
        end

        if (do_idle) begin
          unique case (text_byte)
            CH_LBRACE:   r = add_tok(r, KIND_OBRACE, pos16, LEN_W'(1));
            CH_RBRACE:   r = add_tok(r, KIND_CBRACE, pos16, LEN_W'(1));
            CH_LBRACKET: r = add_tok(r, KIND_OBRACKET, pos16, LEN_W'(1));
            CH_RBRACKET: r = add_tok(r, KIND_CBRACKET, pos16, LEN_W'(1));
            CH_COMMA:    r = add_tok(r, KIND_COMMA, pos16, LEN_W'(1));
            CH_COLON:    r = add_tok(r, KIND_COLON, pos16, LEN_W'(1));
            CH_QUOTE: begin
              mode_next           = MODE_STRING;
              pending_start_next  = pos16;
              pending_length_next = LEN_W'(1);
            end
            CH_T, CH_F: begin
              mode_next             = MODE_KEYWORD;
              pending_start_next    = pos16;
              pending_length_next   = LEN_W'(1);
              keyword_index_next    = 3'd1;
              keyword_is_false_next = (text_byte == CH_F);
            end
            default: begin
              if (is_digit) begin
                mode_next           = MODE_NUMBER;
                pending_start_next  = pos16;
                pending_length_next = LEN_W'(1);
              end
            end
          endcase
        end
      end

      if (end_of_text) begin
        if (mode_next == MODE_STRING || mode_next == MODE_KEYWORD) begin
          r = add_tok(r, KIND_ERROR, pending_start_next, pending_length_next);
        end else if (mode_next == MODE_NUMBER) begin
          r = add_tok(r, KIND_NUMBER, pending_start_next, pending_length_next);
        end
        mode_next             = MODE_IDLE;
        byte_position_next    = '0;
        pending_start_next    = '0;
        pending_length_next   = '0;
        keyword_index_next    = '0;
        keyword_is_false_next = 1'b0;
      end
    end

    rec  = r;
    push = accept && r.v0;
  end

endmodule

>>> sv/jtl_queue.sv
// Short queue of per-byte token records between the front and back ends.
module jtl_queue import jtl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  byte_rec_t push_rec,
  input  logic      pop,
  output logic      full,
  output logic      nonempty,
  output byte_rec_t head
);

  byte_rec_t      entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign full     = (count == (QAW+1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

endmodule

>>> sv/jtl_back.sv
// Back end of the JSON token lexer: splits byte records into single tokens on the output register.
module jtl_back import jtl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        nonempty,
  input  byte_rec_t   head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic        m_tlast
);

  logic second;
  logic load;
  tok_t out_tok;

  assign load = nonempty && (!m_tvalid || m_tready);
  assign pop  = load && (second || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      second   <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        second   <= !second && head.two;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok <= second ? head.t1 : head.t0;
      m_tlast <= second || !head.two;
    end
  end

  assign m_tdata = {3'b000, out_tok};

endmodule

>>> sv/json_token_lexer_unit.sv
// Top level of the JSON token lexer: front end, record queue and back end.
//
//   Channel | Direction | tdata                                  | tlast            | tuser
//   s_*     | in        | [7:0] text_byte                        | end_of_text      | none
//   m_*     | out       | [3:0] kind, [19:4] start, [36:20] len  | result_last      | none
//
// One byte is accepted every cycle while the four-entry record queue has room.
// The back end delivers one token per cycle while m_tready is high, so a byte that causes
// two tokens is delivered as two output tokens in turn; the queue absorbs such bursts.
// Reset clears the lexer state, the byte offset, the queue and the output register.
// Output stalls fill the queue and then hold s_tready low until an entry drains.
module json_token_lexer_unit import jtl_pkg::*; #(
  parameter int unsigned MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] text_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [3:0] token_kind, [19:4] token_start, [36:20] token_length
  output logic        m_tlast
);

  logic      accept;
  logic      push;
  logic      pop;
  logic      full;
  logic      nonempty;
  byte_rec_t push_rec;
  byte_rec_t head;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  jtl_front #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_byte   (s_tdata),
    .end_of_text (s_tlast),
    .push        (push),
    .rec         (push_rec)
  );

  jtl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .full     (full),
    .nonempty (nonempty),
    .head     (head)
  );

  jtl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> sv/jtl_checker.sv
// Port-level checker for the JSON token lexer and its bind to the top level.
module jtl_checker import jtl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  // The output register is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // The record queue is empty after reset, so the input is ready.
  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // Punctuation tokens always cover exactly one byte.
  a_punct_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3:0] <= 4'd5) |-> m_tdata[36:20] == 17'd1)
    else $error("punctuation token with wrong length");

  // A boolean token is the full keyword true or false.
  a_bool_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3:0] == KIND_BOOLEAN) |->
      (m_tdata[36:20] == 17'd4 || m_tdata[36:20] == 17'd5))
    else $error("boolean token with wrong length");

endmodule

bind json_token_lexer_unit jtl_checker u_jtl_checker (.*);

>>> tb/token_stream_checker.sv
// Checker for the JSON token lexer: predicts the token stream from accepted bytes and compares.
module token_stream_checker import jtl_pkg::*; #(
  parameter int unsigned MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  output int          mismatch_count,
  output int          tokens_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    tok_kind_t   kind;
    logic [15:0] start;
    logic [16:0] len;
    logic        last;
  } token_t;

  token_t      expected_tokens[$];
  lex_mode_t   mode = MODE_IDLE;
  logic [31:0] offset = '0;
  logic [15:0] tok_start = '0;
  logic [16:0] tok_len = '0;
  logic [2:0]  kw_idx = '0;
  logic        kw_false = 1'b0;
  int          emitted;

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [7:0] keyword_char(logic is_false, logic [2:0] idx);
    if (is_false) begin
      case (idx)
        3'd0: return CH_F;
        3'd1: return CH_A;
        3'd2: return CH_L;
        3'd3: return CH_S;
        default: return CH_E;
      endcase
    end else begin
      case (idx)
        3'd0: return CH_T;
        3'd1: return CH_R;
        3'd2: return CH_U;
        default: return CH_E;
      endcase
    end
  endfunction

  task automatic push_token(tok_kind_t kind, logic [15:0] start, logic [16:0] len);
    token_t t;
    if (emitted < 2) begin
      t.kind = kind;
      t.start = start;
      t.len = len;
      t.last = 1'b0;
      expected_tokens.push_back(t);
      emitted++;
    end
  endtask

  task automatic clear_token();
    mode = MODE_IDLE;
    tok_start = '0;
    tok_len = '0;
    kw_idx = '0;
    kw_false = 1'b0;
  endtask

  task automatic idle_byte(logic [7:0] c, logic [15:0] at);
    case (c)
      CH_LBRACE:   push_token(KIND_OBRACE, at, 17'd1);
      CH_RBRACE:   push_token(KIND_CBRACE, at, 17'd1);
      CH_LBRACKET: push_token(KIND_OBRACKET, at, 17'd1);
      CH_RBRACKET: push_token(KIND_CBRACKET, at, 17'd1);
      CH_COMMA:    push_token(KIND_COMMA, at, 17'd1);
      CH_COLON:    push_token(KIND_COLON, at, 17'd1);
      CH_QUOTE: begin
        mode = MODE_STRING;
        tok_start = at;
        tok_len = 17'd1;
      end
      CH_T, CH_F: begin
        mode = MODE_KEYWORD;
        tok_start = at;
        tok_len = 17'd1;
        kw_idx = 3'd1;
        kw_false = (c == CH_F);
      end
      default: begin
        if (is_digit(c)) begin
          mode = MODE_NUMBER;
          tok_start = at;
          tok_len = 17'd1;
        end
      end
    endcase
  endtask

  task automatic lex_byte(logic [7:0] c, logic eot);
    logic [15:0] at;
    logic [2:0]  target;
    token_t      tail;
    emitted = 0;
    if (offset < MAX_TEXT_BYTES) begin
      at = offset[15:0];
      offset++;
      case (mode)
        MODE_STRING: begin
          tok_len++;
          if (c == CH_QUOTE) begin
            push_token(KIND_STRING, tok_start, tok_len);
            clear_token();
          end
        end
        MODE_NUMBER: begin
          if (is_digit(c)) begin
            tok_len++;
          end else begin
            push_token(KIND_NUMBER, tok_start, tok_len);
            clear_token();
            idle_byte(c, at);
          end
        end
        MODE_KEYWORD: begin
          target = kw_false ? 3'd5 : 3'd4;
          if (kw_idx < target && c == keyword_char(kw_false, kw_idx)) begin
            kw_idx++;
            tok_len++;
            if (kw_idx >= target) begin
              push_token(KIND_BOOLEAN, tok_start, tok_len);
              clear_token();
            end
          end else begin
            push_token(KIND_ERROR, tok_start, tok_len);
            clear_token();
            idle_byte(c, at);
          end
        end
        default: idle_byte(c, at);
      endcase
    end
    if (eot) begin
      if (mode == MODE_STRING || mode == MODE_KEYWORD) begin
        push_token(KIND_ERROR, tok_start, tok_len);
      end else if (mode == MODE_NUMBER) begin
        push_token(KIND_NUMBER, tok_start, tok_len);
      end
      clear_token();
      offset = '0;
    end
    if (emitted > 0) begin
      tail = expected_tokens.pop_back();
      tail.last = 1'b1;
      expected_tokens.push_back(tail);
    end
  endtask

  task automatic check_token();
    token_t exp;
    if (expected_tokens.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: unexpected token kind %0d start %0d len %0d last %0d", $realtime,
                 m_tdata[3:0], m_tdata[19:4], m_tdata[36:20], m_tlast);
      end
    end else begin
      exp = expected_tokens.pop_front();
      if (m_tdata[3:0] !== exp.kind || m_tdata[19:4] !== exp.start ||
          m_tdata[36:20] !== exp.len || m_tlast !== exp.last) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: token mismatch, expected kind %0d start %0d len %0d last %0d",
                   $realtime, exp.kind, exp.start, exp.len, exp.last);
          $display("%0t:                 got      kind %0d start %0d len %0d last %0d",
                   $realtime, m_tdata[3:0], m_tdata[19:4], m_tdata[36:20], m_tlast);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_token();
      offset = '0;
      expected_tokens.delete();
      mismatch_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        lex_byte(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        check_token();
      end
    end
    tokens_outstanding = expected_tokens.size();
  end

endmodule

>>> tb/tb_json_token_lexer_unit.sv
// Testbench top of the JSON token lexer: clock, reset, byte stimulus, output stalls and verdict.
module tb_json_token_lexer_unit;
  import jtl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  int          mismatch_count;
  int          tokens_outstanding;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stuck_cycles = 0;
  logic [7:0]  text_bytes[$];

  always #1 clk = ~clk;

  json_token_lexer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  token_stream_checker checker_i (
    .clk                (clk),
    .rst                (rst),
    .s_tvalid           (s_tvalid),
    .s_tready           (s_tready),
    .s_tdata            (s_tdata),
    .s_tlast            (s_tlast),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata),
    .m_tlast            (m_tlast),
    .mismatch_count     (mismatch_count),
    .tokens_outstanding (tokens_outstanding)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] c, logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= eot;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++) begin
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
    end
    text_bytes.delete();
  endtask

  task automatic add_string(string s);
    for (int i = 0; i < s.len(); i++) begin
      text_bytes.push_back(s[i]);
    end
  endtask

  task automatic drain_tokens();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (tokens_outstanding != 0);
    @(posedge clk);
  endtask

  task automatic add_fragment();
    int         sel;
    int         n;
    logic [7:0] c;
    logic [7:0] word[$];
    sel = $urandom_range(99);
    if (sel < 15) begin
      case ($urandom_range(5))
        0: text_bytes.push_back(CH_LBRACE);
        1: text_bytes.push_back(CH_RBRACE);
        2: text_bytes.push_back(CH_LBRACKET);
        3: text_bytes.push_back(CH_RBRACKET);
        4: text_bytes.push_back(CH_COMMA);
        default: text_bytes.push_back(CH_COLON);
      endcase
    end else if (sel < 25) begin
      case ($urandom_range(5))
        0: text_bytes.push_back(8'h20);
        1: text_bytes.push_back(8'h09);
        2: text_bytes.push_back(8'h0A);
        3: text_bytes.push_back(8'h0B);
        4: text_bytes.push_back(8'h0C);
        default: text_bytes.push_back(8'h0D);
      endcase
    end else if (sel < 45) begin
      text_bytes.push_back(CH_QUOTE);
      n = $urandom_range(6);
      repeat (n) begin
        c = 8'($urandom_range(255));
        if (c == CH_QUOTE) c = CH_A;
        text_bytes.push_back(c);
      end
      if ($urandom_range(9) != 0) text_bytes.push_back(CH_QUOTE);
    end else if (sel < 65) begin
      n = $urandom_range(1, 5);
      repeat (n) text_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
    end else if (sel < 88) begin
      if ($urandom_range(1) != 0) word = '{CH_F, CH_A, CH_L, CH_S, CH_E};
      else word = '{CH_T, CH_R, CH_U, CH_E};
      if (sel < 80) begin
        foreach (word[i]) text_bytes.push_back(word[i]);
      end else begin
        n = $urandom_range(1, word.size() - 1);
        for (int i = 0; i < n; i++) text_bytes.push_back(word[i]);
        text_bytes.push_back(8'($urandom_range(255)));
      end
    end else begin
      text_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic run_texts(int byte_goal);
    int sent;
    sent = 0;
    while (sent < byte_goal) begin
      repeat ($urandom_range(1, 12)) add_fragment();
      sent += text_bytes.size();
      send_text();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 55;
    add_string("{\"a\": [9,true]}");
    send_text();
    drain_tokens();
    add_string("fa:");
    send_text();
    add_string("\"x");
    send_text();
    text_bytes = '{8'h00, 8'hFF, 8'h37};
    send_text();
    add_string("false3\"");
    send_text();
    run_texts(400);

    send_idle_pct = 55;
    recv_idle_pct = 7;
    run_texts(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_texts(400);

    drain_tokens();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && tokens_outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
